### design/sfw_pkg.sv
// Shared types and constants for the slot semaphore with a FIFO waiter queue.
// Used by every module of the block; depends on nothing else.
package sfw_pkg;

    localparam logic [1:0] ACT_ACQUIRE = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_CANCEL  = 2'd2;

    localparam logic [2:0] ST_GRANTED    = 3'd0;
    localparam logic [2:0] ST_QUEUED     = 3'd1;
    localparam logic [2:0] ST_HANDED     = 3'd2;
    localparam logic [2:0] ST_FREED      = 3'd3;
    localparam logic [2:0] ST_UNBALANCED = 3'd4;
    localparam logic [2:0] ST_FULL       = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd6;

    localparam logic [7:0] SLOT_LIMIT_RESET = 8'd6;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] requester_tag;
    } req_beat_t;

    typedef struct packed {
        logic [2:0] status;
        logic       grant_valid;
        logic [7:0] grantee_tag;
        logic [7:0] active_count;
        logic [4:0] waiting_count;
    } rsp_beat_t;

    typedef struct packed {
        logic       cancelled;
        logic [7:0] tag;
    } waiter_t;

endpackage

### design/sfw_wait_ram.sv
// Waiter queue storage: one write port and one registered read port.
// Depends on sfw_pkg for the entry type.
module sfw_wait_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  sfw_pkg::waiter_t     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output sfw_pkg::waiter_t     rd_data
);

    sfw_pkg::waiter_t mem [DEPTH];
    sfw_pkg::waiter_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/sfw_ctrl.sv
// Sequencer that runs acquire, release and cancel over the waiter queue,
// one entry examined at a time. Depends on sfw_pkg.
module sfw_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PTR_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  sfw_pkg::req_beat_t   req_beat,
    input  logic [7:0]           slot_limit,
    output logic                 res_valid,
    input  logic                 res_ready,
    output sfw_pkg::rsp_beat_t   res_beat,
    output logic                 mem_wr_en,
    output logic [PTR_W-1:0]     mem_wr_addr,
    output sfw_pkg::waiter_t     mem_wr_data,
    output logic                 mem_rd_en,
    output logic [PTR_W-1:0]     mem_rd_addr,
    input  sfw_pkg::waiter_t     mem_rd_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACQ   = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [2:0]       state_reg, state_next;
    logic [7:0]       held_reg, held_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0] scan_left_reg, scan_left_next;
    logic [1:0]       action_reg, action_next;
    logic [7:0]       tag_reg, tag_next;
    logic [2:0]       status_reg, status_next;
    logic             grant_reg, grant_next;
    logic [7:0]       gtag_reg, gtag_next;
    logic [PTR_W-1:0] scan_ptr_inc;
    logic             tag_match;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == LAST_PTR)
        begin
            r = '0;
        end
        else
        begin
            r = PTR_W'(p + 1'b1);
        end
        return r;
    endfunction

    // The one pointer stepper shared by every scan step, and the tag comparator used by cancel scan steps.
    assign scan_ptr_inc = next_ptr(scan_ptr_reg);
    assign tag_match    = !mem_rd_data.cancelled && (mem_rd_data.tag == tag_reg);

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_left_next = scan_left_reg;
        action_next    = action_reg;
        tag_next       = tag_reg;
        status_next    = status_reg;
        grant_next     = grant_reg;
        gtag_next      = gtag_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = tail_reg;
        mem_wr_data    = '{cancelled: 1'b0, tag: tag_reg};
        mem_rd_en      = 1'b0;
        mem_rd_addr    = scan_ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    action_next    = req_beat.action;
                    tag_next       = req_beat.requester_tag;
                    scan_ptr_next  = head_reg;
                    scan_left_next = fill_reg;
                    status_next    = sfw_pkg::ST_NOT_FOUND;
                    grant_next     = 1'b0;
                    gtag_next      = 8'd0;
                    unique case (req_beat.action) inside
                        sfw_pkg::ACT_ACQUIRE: state_next = S_ACQ;
                        sfw_pkg::ACT_RELEASE,
                        sfw_pkg::ACT_CANCEL:  state_next = S_READ;
                        default:              state_next = S_DONE;
                    endcase
                end
            end
            S_ACQ:
            begin
                if (held_reg < slot_limit)
                begin
                    held_next   = 8'(held_reg + 1'b1);
                    status_next = sfw_pkg::ST_GRANTED;
                    grant_next  = 1'b1;
                    gtag_next   = tag_reg;
                end
                else if (fill_reg == FULL_CNT)
                begin
                    status_next = sfw_pkg::ST_FULL;
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = tail_reg;
                    tail_next   = next_ptr(tail_reg);
                    fill_next   = CNT_W'(fill_reg + 1'b1);
                    status_next = sfw_pkg::ST_QUEUED;
                end
                state_next = S_DONE;
            end
            S_READ:
            begin
                if (scan_left_reg == '0)
                begin
                    if (action_reg == sfw_pkg::ACT_RELEASE)
                    begin
                        if (held_reg != 8'd0)
                        begin
                            held_next   = 8'(held_reg - 1'b1);
                            status_next = sfw_pkg::ST_FREED;
                        end
                        else
                        begin
                            status_next = sfw_pkg::ST_UNBALANCED;
                        end
                    end
                    else
                    begin
                        status_next = sfw_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                scan_ptr_next  = scan_ptr_inc;
                scan_left_next = CNT_W'(scan_left_reg - 1'b1);
                state_next     = S_READ;
                if (action_reg == sfw_pkg::ACT_RELEASE)
                begin
                    head_next = scan_ptr_inc;
                    fill_next = CNT_W'(fill_reg - 1'b1);
                    if (!mem_rd_data.cancelled)
                    begin
                        status_next = sfw_pkg::ST_HANDED;
                        grant_next  = 1'b1;
                        gtag_next   = mem_rd_data.tag;
                        state_next  = S_DONE;
                    end
                end
                else if (tag_match)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = scan_ptr_reg;
                    mem_wr_data = '{cancelled: 1'b1, tag: mem_rd_data.tag};
                    status_next = sfw_pkg::ST_QUEUED;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= 8'd0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_ptr_reg  <= scan_ptr_next;
        scan_left_reg <= scan_left_next;
        action_reg    <= action_next;
        tag_reg       <= tag_next;
        status_reg    <= status_next;
        grant_reg     <= grant_next;
        gtag_reg      <= gtag_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res_beat.status        = status_reg;
        res_beat.grant_valid   = grant_reg;
        res_beat.grantee_tag   = gtag_reg;
        res_beat.active_count  = held_reg;
        res_beat.waiting_count = 5'(fill_reg);
    end

endmodule

### design/slot_semaphore_fifo_waiters.sv
// Top level of the counting semaphore with a FIFO waiter queue.
// Depends on sfw_pkg, sfw_wait_ram and sfw_ctrl.
//
// Each request beat gives exactly one response beat. An acquire passes through
// the acquire state to the done state; unused action codes go straight to done.
// From done the response moves to the output register and the sequencer returns
// to idle for the next request beat. Release and cancel add a read and a check
// state for every queued entry they examine, since the waiter queue has one read
// port with registered data and the sequencer reads and checks one entry at a
// time. A new request is taken while the last response still sits in the output
// register, but a further response waits until that one is taken. The slot limit
// register resets to six and should be written only while the block is idle. The
// waiting count reports the low five bits of the queue fill.
module slot_semaphore_fifo_waiters #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  sfw_pkg::req_beat_t   req_beat,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output sfw_pkg::rsp_beat_t   rsp_beat,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]          slot_limit_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    sfw_pkg::rsp_beat_t  rsp_beat_reg;
    logic                res_valid;
    logic                res_ready;
    sfw_pkg::rsp_beat_t  res_beat;
    logic                mem_wr_en;
    logic [PTR_W-1:0]    mem_wr_addr;
    sfw_pkg::waiter_t    mem_wr_data;
    logic                mem_rd_en;
    logic [PTR_W-1:0]    mem_rd_addr;
    sfw_pkg::waiter_t    mem_rd_data;

    sfw_wait_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    sfw_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_beat    (req_beat),
        .slot_limit  (slot_limit_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_beat    (res_beat),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit_reg <= sfw_pkg::SLOT_LIMIT_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                slot_limit_reg <= cfg_wdata;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_beat_reg <= res_beat;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

endmodule
